// ===== hw/rtl/vmes_pkg.sv =====
// Package for the evaluation stack unit: opcodes, status codes, sequencer states.
// No dependencies.
package vmes_pkg;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,  OP_DEPTH = 4'd1,  OP_DROP = 4'd2,  OP_NIP  = 4'd3,
    OP_XDROP = 4'd4,  OP_CLEAR = 4'd5,  OP_DUP  = 4'd6,  OP_OVER = 4'd7,
    OP_PICK  = 4'd8,  OP_TUCK  = 4'd9,  OP_SWAP = 4'd10, OP_ROT  = 4'd11,
    OP_ROLL  = 4'd12, OP_REV3  = 4'd13, OP_REV4 = 4'd14, OP_REVN = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_UNDER = 3'd1, ST_NEG = 3'd2, ST_RANGE = 3'd3, ST_OVER = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SH_HOLD, S_SH_RD, S_SH_WR, S_SH_PARK, S_CP_WR,
    S_RV_HI, S_RV_WRLO, S_RV_WRHI, S_TOP_RD, S_RESULT
  } state_t;

  // word move patterns run by the sequencer
  typedef enum logic [1:0] {
    MV_NONE, MV_SHIFT, MV_COPY, MV_REV
  } mv_t;

endpackage

// ===== hw/rtl/vm_evaluation_stack_unit.sv =====
// Evaluation stack unit: 64-bit word stack in one synchronous RAM, one opcode per request.
// Requests are taken only while idle (busy low); the next request is accepted once the result
// strobe has been shown, so one request is in flight at a time. The receiver cannot stall;
// each result strobe lasts one cycle. Reset (synchronous, rst_n low) empties the stack; RAM
// contents are not cleared. Depends on vmes_pkg.
module vm_evaluation_stack_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [3:0]                        in_kind,
  input  logic signed [63:0]                in_push_value,
  output logic                              out_valid,
  output logic [2:0]                        out_status,
  output logic [$clog2(STACK_DEPTH+1)-1:0]  out_stack_depth,
  output logic signed [63:0]                out_top_word,
  output logic                              out_top_valid
);
  import vmes_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [CW-1:0] C1   = CW'(1);
  localparam logic [CW-1:0] C2   = CW'(2);
  localparam logic [CW-1:0] C3   = CW'(3);
  localparam logic [CW-1:0] C4   = CW'(4);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  // Every opcode is a decision cycle (with at most one direct write), then an
  // optional move pattern over a RAM range, then a reread of the new top word.
  // The RAM is the only copy of the stack; top_r mirrors mem[cnt-1] between
  // requests. Each read is issued only after the last write to any entry it may
  // touch, so no forwarding path is needed.

  logic [63:0]   mem [STACK_DEPTH];
  logic [63:0]   rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;      // committed depth
  op_t           op_r, op_nxt;
  logic [63:0]   pv_r, pv_nxt;
  status_t       st_r, st_nxt;
  logic [CW-1:0] cfin_r, cfin_nxt;    // depth after the request
  logic [63:0]   top_r, top_nxt;      // copy of mem[cnt-1]
  logic [63:0]   hold_r, hold_nxt;    // word parked during a shift or a reversal
  logic [AW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic          keep_r, keep_nxt;    // shift ends by writing hold at hi

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      cfin_r  <= '0;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cfin_r  <= cfin_nxt;
      st_r    <= st_nxt;
    end
    op_r   <= op_nxt;
    pv_r   <= pv_nxt;
    top_r  <= top_nxt;
    hold_r <= hold_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    keep_r <= keep_nxt;
  end

  // Decision for the captured opcode. In S_DECIDE top_r is the top word (the
  // count n for index opcodes) and rd_data_r holds mem[cnt-2].
  logic [63:0]   v;
  logic [CW-1:0] m;
  logic [CW-1:0] vn;
  status_t       dec_st;
  logic [CW-1:0] dec_cfin;
  logic          dec_wr;
  logic [AW-1:0] dec_wr_addr;
  logic [63:0]   dec_wr_data;
  mv_t           dec_mv;
  logic [AW-1:0] dec_lo, dec_hi;
  logic          dec_keep;
  logic          rv_more;

  assign v  = top_r;
  assign m  = cnt_r - C1;
  assign vn = v[CW-1:0];
  // another swap pair remains after the current one
  assign rv_more = (lo_r + 1'b1) < (hi_r - 1'b1);

  always_comb begin
    dec_st = ST_OK; dec_cfin = cnt_r; dec_wr = 1'b0;
    dec_wr_addr = AW'(cnt_r); dec_wr_data = top_r;
    dec_mv = MV_NONE; dec_lo = '0; dec_hi = '0; dec_keep = 1'b0;
    case (op_r)
      OP_PUSH, OP_DEPTH: begin
        if (cnt_r >= FULL) dec_st = ST_OVER;
        else begin
          dec_wr = 1'b1;
          dec_wr_data = (op_r == OP_PUSH) ? pv_r : 64'(cnt_r);
          dec_cfin = cnt_r + C1;
        end
      end
      OP_DROP: begin
        if (cnt_r < C1) dec_st = ST_UNDER;
        else dec_cfin = cnt_r - C1;
      end
      OP_NIP: begin
        if (cnt_r < C2) dec_st = ST_UNDER;
        else begin
          dec_wr = 1'b1; dec_wr_addr = AW'(cnt_r - C2);
          dec_cfin = cnt_r - C1;
        end
      end
      OP_CLEAR: dec_cfin = '0;
      OP_DUP: begin
        if (cnt_r < C1) dec_st = ST_UNDER;
        else if (cnt_r >= FULL) dec_st = ST_OVER;
        else begin
          dec_wr = 1'b1; dec_cfin = cnt_r + C1;
        end
      end
      OP_OVER: begin
        if (cnt_r < C2) dec_st = ST_UNDER;
        else if (cnt_r >= FULL) dec_st = ST_OVER;
        else begin
          dec_wr = 1'b1; dec_wr_data = rd_data_r; dec_cfin = cnt_r + C1;
        end
      end
      OP_TUCK: begin
        // a b -> b a b: copy b above, then swap the old pair
        if (cnt_r < C2) dec_st = ST_UNDER;
        else if (cnt_r >= FULL) dec_st = ST_OVER;
        else begin
          dec_wr = 1'b1; dec_cfin = cnt_r + C1;
          dec_mv = MV_REV; dec_lo = AW'(cnt_r - C2); dec_hi = AW'(cnt_r - C1);
        end
      end
      OP_SWAP: begin
        if (cnt_r < C2) dec_st = ST_UNDER;
        else begin
          dec_mv = MV_REV; dec_lo = AW'(cnt_r - C2); dec_hi = AW'(cnt_r - C1);
        end
      end
      OP_ROT: begin
        // a b c -> b c a: shift the three down, old bottom lands on top
        if (cnt_r < C3) dec_st = ST_UNDER;
        else begin
          dec_mv = MV_SHIFT; dec_lo = AW'(cnt_r - C3); dec_hi = AW'(cnt_r - C1);
          dec_keep = 1'b1;
        end
      end
      OP_REV3: begin
        if (cnt_r < C3) dec_st = ST_UNDER;
        else begin
          dec_mv = MV_REV; dec_lo = AW'(cnt_r - C3); dec_hi = AW'(cnt_r - C1);
        end
      end
      OP_REV4: begin
        if (cnt_r < C4) dec_st = ST_UNDER;
        else begin
          dec_mv = MV_REV; dec_lo = AW'(cnt_r - C4); dec_hi = AW'(cnt_r - C1);
        end
      end
      default: begin
        // xdrop, pick, roll, revn: n is the top word, positions count below it
        if (cnt_r < C1) dec_st = ST_UNDER;
        else if (v[63]) dec_st = ST_NEG;
        else if (op_r == OP_PICK) begin
          if (v >= 64'(m)) dec_st = ST_UNDER;
          else begin
            dec_mv = MV_COPY; dec_lo = AW'(cnt_r - C2 - vn); dec_hi = AW'(cnt_r - C1);
          end
        end else if ((op_r == OP_ROLL && v == 64'd0) ||
                     (op_r == OP_REVN && v <= 64'd1)) begin
          dec_cfin = cnt_r - C1;
        end else if (op_r == OP_REVN) begin
          if (v > 64'(m)) dec_st = ST_RANGE;
          else begin
            dec_mv = MV_REV; dec_lo = AW'(cnt_r - C1 - vn); dec_hi = AW'(cnt_r - C2);
            dec_cfin = cnt_r - C1;
          end
        end else if (v >= 64'(m)) dec_st = ST_RANGE;
        else begin
          // remove the word at position n; roll parks it just under n
          dec_mv = MV_SHIFT; dec_lo = AW'(cnt_r - C2 - vn); dec_hi = AW'(cnt_r - C2);
          dec_keep = (op_r == OP_ROLL);
          dec_cfin = (op_r == OP_ROLL) ? cnt_r - C1 : cnt_r - C2;
        end
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (start) state_nxt = S_DECIDE;
      S_DECIDE: begin
        case (dec_mv)
          MV_SHIFT: state_nxt = S_SH_HOLD;
          MV_COPY:  state_nxt = S_CP_WR;
          MV_REV:   state_nxt = S_RV_HI;
          default:  state_nxt = S_TOP_RD;
        endcase
      end
      S_SH_HOLD: state_nxt = S_SH_RD;
      S_SH_RD: begin
        if (lo_r < hi_r) state_nxt = S_SH_WR;
        else if (keep_r) state_nxt = S_SH_PARK;
        else state_nxt = S_TOP_RD;
      end
      S_SH_WR:   state_nxt = S_SH_RD;
      S_SH_PARK: state_nxt = S_TOP_RD;
      S_CP_WR:   state_nxt = S_TOP_RD;
      S_RV_HI:   state_nxt = S_RV_WRLO;
      S_RV_WRLO: state_nxt = S_RV_WRHI;
      S_RV_WRHI: state_nxt = rv_more ? S_RV_HI : S_TOP_RD;
      S_TOP_RD:  state_nxt = S_RESULT;
      S_RESULT:  state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // RAM control and datapath registers
  always_comb begin
    rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = rd_data_r;
    cnt_nxt = cnt_r; op_nxt = op_r; pv_nxt = pv_r; st_nxt = st_r; cfin_nxt = cfin_r;
    top_nxt = top_r; hold_nxt = hold_r; lo_nxt = lo_r; hi_nxt = hi_r; keep_nxt = keep_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = op_t'(in_kind);
          pv_nxt = in_push_value;
          rd_en = 1'b1; rd_addr = AW'(cnt_r - C2);   // second word, used by over
        end
      end
      S_DECIDE: begin
        st_nxt = dec_st; cfin_nxt = dec_cfin;
        lo_nxt = dec_lo; hi_nxt = dec_hi; keep_nxt = dec_keep;
        wr_en = dec_wr; wr_addr = dec_wr_addr; wr_data = dec_wr_data;
        if (dec_mv != MV_NONE) begin
          rd_en = 1'b1; rd_addr = dec_lo;
        end
      end
      S_SH_HOLD: hold_nxt = rd_data_r;                 // word at lo
      S_SH_RD: begin
        if (lo_r < hi_r) begin
          rd_en = 1'b1; rd_addr = lo_r + 1'b1;
        end
      end
      S_SH_WR: begin
        wr_en = 1'b1; wr_addr = lo_r; wr_data = rd_data_r;
        lo_nxt = lo_r + 1'b1;
      end
      S_SH_PARK: begin
        wr_en = 1'b1; wr_addr = hi_r; wr_data = hold_r;
      end
      S_CP_WR: begin
        wr_en = 1'b1; wr_addr = hi_r; wr_data = rd_data_r;
      end
      S_RV_HI: begin
        hold_nxt = rd_data_r;                          // word at lo
        rd_en = 1'b1; rd_addr = hi_r;
      end
      S_RV_WRLO: begin
        wr_en = 1'b1; wr_addr = lo_r; wr_data = rd_data_r;
      end
      S_RV_WRHI: begin
        wr_en = 1'b1; wr_addr = hi_r; wr_data = hold_r;
        lo_nxt = lo_r + 1'b1; hi_nxt = hi_r - 1'b1;
        if (rv_more) begin
          rd_en = 1'b1; rd_addr = lo_r + 1'b1;
        end
      end
      S_TOP_RD: begin
        rd_en = 1'b1; rd_addr = AW'(cfin_r - C1);
      end
      S_RESULT: begin
        cnt_nxt = cfin_r;
        top_nxt = rd_data_r;
      end
      default: ;
    endcase
  end

  // Result is presented in S_RESULT: depth from cfin_r, top word straight from RAM.
  assign busy            = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_RESULT);
  assign out_status      = st_r;
  assign out_stack_depth = cfin_r;
  assign out_top_valid   = (cfin_r != '0);
  assign out_top_word    = (cfin_r != '0) ? rd_data_r : 64'd0;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL) else $error("depth beyond capacity");
  a_fault_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_stack_depth == cnt_r)
    else $error("fault changed depth");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("strobe while idle");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one cycle");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for vm_evaluation_stack_unit: random and directed stack opcodes,
// with results checked against a behavioral stack predictor. Depends on vmes_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vmes_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1100;

  typedef struct {
    op_t         kind;
    logic [63:0] value;
    int          pre_gap;  // idle cycles before this request is offered
    bit          drain;    // hold until every outstanding result is back
  } request_t;

  typedef struct {
    status_t     status;
    logic [6:0]  depth;
    logic [63:0] top;
    logic        top_valid;
  } stack_view_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [3:0]  in_kind;
  logic signed [63:0] in_push_value;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [6:0]  out_stack_depth;
  logic signed [63:0] out_top_word;
  logic        out_top_valid;

  vm_evaluation_stack_unit #(.STACK_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_push_value(in_push_value),
    .out_valid(out_valid), .out_status(out_status), .out_stack_depth(out_stack_depth),
    .out_top_word(out_top_word), .out_top_valid(out_top_valid)
  );

  // Shadow stack: position cnt-1 is the top word.
  logic [63:0] shadow[DEPTH];
  int          shadow_cnt;

  request_t    pending_q[$];
  stack_view_t expected_q[$];
  bit          req_taken;
  int          idle_cnt;
  int          cycles;
  bit          failed;
  bit          gen_done;
  bit          calm;       // stretch with no idling at all
  int          n_items;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Push helper for the predictor; full stack reports overflow.
  function automatic status_t shadow_push(logic [63:0] w);
    if (shadow_cnt >= DEPTH) return ST_OVER;
    shadow[shadow_cnt] = w;
    shadow_cnt++;
    return ST_OK;
  endfunction

  function automatic stack_view_t predict_stack(op_t k, logic [63:0] pv);
    stack_view_t r;
    status_t     st;
    int          c, m, pos, lo, hi;
    logic [63:0] t, v;
    c  = shadow_cnt;
    st = ST_OK;
    case (k)
      OP_PUSH:  st = shadow_push(pv);
      OP_DEPTH: st = shadow_push(64'(c));
      OP_DROP:  if (c < 1) st = ST_UNDER; else shadow_cnt = c - 1;
      OP_NIP: begin
        if (c < 2) st = ST_UNDER;
        else begin
          shadow[c-2] = shadow[c-1];
          shadow_cnt = c - 1;
        end
      end
      OP_CLEAR: shadow_cnt = 0;
      OP_DUP:   if (c < 1) st = ST_UNDER; else st = shadow_push(shadow[c-1]);
      OP_OVER:  if (c < 2) st = ST_UNDER; else st = shadow_push(shadow[c-2]);
      OP_TUCK: begin
        if (c < 2) st = ST_UNDER;
        else if (c >= DEPTH) st = ST_OVER;
        else begin
          t = shadow[c-1];
          shadow[c-1] = shadow[c-2];
          shadow[c-2] = t;
          shadow[c] = t;
          shadow_cnt = c + 1;
        end
      end
      OP_SWAP: begin
        if (c < 2) st = ST_UNDER;
        else begin
          t = shadow[c-1]; shadow[c-1] = shadow[c-2]; shadow[c-2] = t;
        end
      end
      OP_ROT: begin
        // a b c -> b c a
        if (c < 3) st = ST_UNDER;
        else begin
          t = shadow[c-3];
          shadow[c-3] = shadow[c-2];
          shadow[c-2] = shadow[c-1];
          shadow[c-1] = t;
        end
      end
      OP_REV3, OP_REV4: begin
        m = (k == OP_REV3) ? 3 : 4;
        if (c < m) st = ST_UNDER;
        else for (lo = c - m, hi = c - 1; lo < hi; lo++, hi--) begin
          t = shadow[lo]; shadow[lo] = shadow[hi]; shadow[hi] = t;
        end
      end
      default: begin
        // xdrop, pick, roll, revn: count n is popped from the top
        if (c < 1) st = ST_UNDER;
        else begin
          v = shadow[c-1];
          m = c - 1;
          if (v[63]) st = ST_NEG;
          else if (k == OP_PICK) begin
            if (v >= 64'(m)) st = ST_UNDER;
            else shadow[c-1] = shadow[c-2-int'(v)];
          end else if (k == OP_ROLL && v == 0) shadow_cnt = c - 1;
          else if (k == OP_REVN && v <= 1) shadow_cnt = c - 1;
          else if (k == OP_REVN) begin
            if (v > 64'(m)) st = ST_RANGE;
            else begin
              for (lo = c - 1 - int'(v), hi = c - 2; lo < hi; lo++, hi--) begin
                t = shadow[lo]; shadow[lo] = shadow[hi]; shadow[hi] = t;
              end
              shadow_cnt = c - 1;
            end
          end else if (v >= 64'(m)) st = ST_RANGE;
          else begin
            pos = c - 2 - int'(v);
            t = shadow[pos];
            for (lo = pos; lo < c - 2; lo++) shadow[lo] = shadow[lo+1];
            if (k == OP_XDROP) shadow_cnt = c - 2;
            else begin
              shadow[c-2] = t;
              shadow_cnt = c - 1;
            end
          end
        end
      end
    endcase
    r.status    = st;
    r.depth     = 7'(shadow_cnt);
    r.top       = (shadow_cnt > 0) ? shadow[shadow_cnt-1] : 64'd0;
    r.top_valid = (shadow_cnt > 0);
    return r;
  endfunction

  // Mostly back-to-back or short gaps, a few long ones; none during calm stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_req(op_t k, logic [63:0] v, bit d = 1'b0);
    request_t q;
    q.kind = k; q.value = v; q.pre_gap = pick_gap(); q.drain = d;
    pending_q = {pending_q, q};
    n_items++;
    if (n_items % 60 == 0) calm = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic op_t index_op();
    case ($urandom_range(0, 3))
      0: return OP_XDROP;
      1: return OP_PICK;
      2: return OP_ROLL;
      default: return OP_REVN;
    endcase
  endfunction

  // Stimulus generation
  initial begin
    int r, i;
    gen_done = 1'b0;
    calm = 1'b0;
    n_items = 0;
    // Directed: every opcode that needs operands, on an empty stack -> underflow
    add_req(OP_DROP, 0); add_req(OP_NIP, 0); add_req(OP_XDROP, 0);
    add_req(OP_PICK, 0); add_req(OP_ROLL, 0); add_req(OP_REVN, 0);
    add_req(OP_DUP, 0);  add_req(OP_OVER, 0); add_req(OP_TUCK, 0);
    add_req(OP_SWAP, 0); add_req(OP_ROT, 0);  add_req(OP_REV3, 0);
    add_req(OP_REV4, 0); add_req(OP_CLEAR, 0);
    // Field extremes, depth, the small permutations, then a negative count
    add_req(OP_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
    add_req(OP_PUSH, 64'h8000_0000_0000_0000);
    add_req(OP_PUSH, 64'd0);
    add_req(OP_DEPTH, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(OP_ROT, 0);
    add_req(OP_REV4, 0);
    add_req(OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(OP_PICK, 0);                  // negative index
    add_req(OP_PUSH, 64'd0);
    add_req(OP_ROLL, 0);                  // roll 0 only consumes n
    add_req(OP_PUSH, 64'd1, 1'b1);        // wait for all results first
    add_req(OP_REVN, 0);                  // revn 1 only consumes n

    while (n_items < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 30) add_req(OP_PUSH, ($urandom_range(0, 1)) ? rand_word() : 64'($urandom_range(0, 9)));
      else if (r < 50) begin
        add_req(OP_PUSH, 64'($urandom_range(0, 12)));
        add_req(index_op(), rand_word());
      end else if (r < 54) begin
        add_req(OP_PUSH, 64'($urandom_range(0, 66)));
        add_req(index_op(), 0);
      end else if (r < 56) begin
        add_req(OP_PUSH, rand_word() | 64'h8000_0000_0000_0000);
        add_req(index_op(), 0);
      end else if (r < 58) begin
        add_req(OP_PUSH, rand_word());
        add_req(index_op(), 0);
      end else if (r < 60) add_req(OP_CLEAR, rand_word());
      else if (r < 61) begin
        // fill to the top and hit overflow on every growing opcode
        for (i = 0; i < 66; i++) add_req(OP_PUSH, rand_word());
        add_req(OP_DEPTH, 0); add_req(OP_DUP, 0); add_req(OP_OVER, 0); add_req(OP_TUCK, 0);
        add_req(OP_PUSH, 64'($urandom_range(30, 63)));
        add_req(index_op(), 0);
      end else if (r < 62) add_req(OP_DEPTH, rand_word(), 1'b1);
      else add_req(op_t'($urandom_range(1, 15)), rand_word());
    end
    gen_done = 1'b1;
  end

  // Reset and input init
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = OP_PUSH;
    in_push_value = '0;
    shadow_cnt = 0;
    failed = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Driver: offers the next request at the falling edge, holds it until accepted.
  always @(negedge clk) begin
    if (rst_n && (!start || req_taken)) begin
      if (pending_q.size() > 0 && idle_cnt < pending_q[0].pre_gap) begin
        idle_cnt <= idle_cnt + 1;
        start <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   !(pending_q[0].drain && (expected_q.size() > 0 || busy))) begin
        in_kind       <= pending_q[0].kind;
        in_push_value <= pending_q[0].value;
        start         <= 1'b1;
        idle_cnt      <= 0;
        void'(pending_q.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Acceptance: predict each request as it is taken.
  always @(posedge clk) begin
    req_taken <= rst_n && start && !busy;
    if (rst_n && start && !busy)
      expected_q = {expected_q, predict_stack(op_t'(in_kind), in_push_value)};
  end

  // Monitor: compare each result strobe with the oldest expectation.
  always @(posedge clk) begin
    stack_view_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d depth=%0d top=%h",
                 $time, out_status, out_stack_depth, out_top_word);
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        if (out_status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
          failed = 1'b1;
        end
        if (out_stack_depth !== e.depth) begin
          $display("%0t: depth exp %0d got %0d", $time, e.depth, out_stack_depth);
          failed = 1'b1;
        end
        if (out_top_word !== e.top) begin
          $display("%0t: top word exp %h got %h", $time, e.top, out_top_word);
          failed = 1'b1;
        end
        if (out_top_valid !== e.top_valid) begin
          $display("%0t: top valid exp %0b got %0b", $time, e.top_valid, out_top_valid);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog
  initial cycles = 0;
  initial idle_cnt = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // End of run: all requests taken, all results back, then a quiet tail.
  initial begin
    @(posedge rst_n);
    while (!gen_done || pending_q.size() > 0 || start || expected_q.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
    if (!failed && expected_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
